[rtl/bsa_pkg.sv]
// Shared constants, codes and types for the block slot allocator.
package bsa_pkg;

    localparam int FREE_DEPTH = 256;
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int ADDR_W     = $clog2(FREE_DEPTH);

    localparam int IDX_W      = 32;
    localparam int FLD_W      = 16;
    localparam int BLK_CNT_W  = FLD_W + 1;
    localparam int DIV_CNT_W  = $clog2(IDX_W);

    localparam logic [FLD_W-1:0] EPB_RESET = FLD_W'(1);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    // Control between the sequencer and the divider.
    typedef struct packed {
        logic              start;
        logic [IDX_W-1:0]  dividend;
        logic [FLD_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [IDX_W-1:0]  quot;
        logic [FLD_W-1:0]  rem;
    } t_div_rsp;

endpackage

[rtl/bsa_ifs.sv]
// Channel interfaces of the block slot allocator: configuration, command and result.
interface bsa_cfg_if import bsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [FLD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsa_in_if import bsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [FLD_W-1:0] free_block;
    logic [FLD_W-1:0] free_offset;

    modport source (output valid, output cmd, output free_block, output free_offset,
                    input ready);
    modport sink   (input valid, input cmd, input free_block, input free_offset,
                    output ready);
endinterface

interface bsa_out_if import bsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [FLD_W-1:0] slot_block;
    logic [FLD_W-1:0] slot_offset;
    logic             new_block;

    modport source (output valid, output status, output slot_block, output slot_offset,
                    output new_block, input ready);
    modport sink   (input valid, input status, input slot_block, input slot_offset,
                    input new_block, output ready);
endinterface

[rtl/bsa_div.sv]
// Radix-2 restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
module bsa_div import bsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0]     r_nq;     // dividend bits shift out, quotient bits shift in
    logic [FLD_W-1:0]     r_rem;
    logic [FLD_W-1:0]     r_dvs;

    logic [FLD_W:0]       w_sh;
    logic [FLD_W:0]       w_diff;
    logic                 w_qbit;

    assign w_sh   = {r_rem, r_nq[IDX_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_qbit = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(IDX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_nq  <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_nq  <= {r_nq[IDX_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[FLD_W-1:0] : w_sh[FLD_W-1:0];
        end
    end

    assign o_rsp = '{done: r_done, quot: r_nq, rem: r_rem};

endmodule

[rtl/block_slot_allocator.sv]
// Top level of the block slot allocator: LIFO free stack, fresh counter and split divider.
//
// Usage:
// - i_cfg writes entries_per_block (slots per storage block, 0 acts as 1, reset value 1);
//   always ready. The user must write it only while no command is in flight (unenforced).
// - i_in carries one command per transaction: allocate (pop the last freed linear index,
//   or else take the next fresh index) or free (block * entries_per_block + offset is
//   pushed). Each command yields exactly one result transaction on o_out.
// - An allocation splits the index with a shared radix-2 divider, one quotient bit per
//   cycle: an index from the fresh counter starts the divider at acceptance, one popped
//   from the stack first waits in S_LOAD for the registered stack read. The divider sets
//   the rate. A free multiplies at acceptance, then adds and pushes when its result is
//   loaded. The next command is accepted at the earliest once the sequencer is back in
//   S_IDLE after a result is loaded.
// - One command is worked on at a time; i_in is ready only while the sequencer is idle.
//   A finished result sits in the output register, so the next command is accepted
//   while the receiver stalls; the sequencer then holds at its final step until the
//   output register frees up, and commits state only when the result is loaded.
// - Reset clears the stack count, fresh counter and block count at once; the stack
//   memory needs no clearing pass, since only entries below the count are read.
module block_slot_allocator import bsa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsa_cfg_if.sink    i_cfg,
    bsa_in_if.sink     i_in,
    bsa_out_if.source  o_out
);

    // Sequencer and configuration.
    t_state               r_state, n_state;
    logic [FLD_W-1:0]     r_epb;

    // Allocator state.
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_fresh;
    logic [BLK_CNT_W-1:0] r_blocks;
    logic [IDX_W-1:0]     r_stack [FREE_DEPTH];
    logic [IDX_W-1:0]     r_rd_data;

    // Captured command.
    t_cmd                 r_cmd;
    logic                 r_full;
    logic                 r_from_stack;
    logic [FLD_W-1:0]     r_off;
    logic [IDX_W-1:0]     r_prod;

    // Output register.
    logic                 r_out_valid;
    t_status              r_status;
    logic [FLD_W-1:0]     r_blk;
    logic [FLD_W-1:0]     r_boff;
    logic                 r_new;

    logic [FLD_W-1:0]     w_per;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_commit;
    logic [CNT_W-1:0]     w_count_m1;
    logic [IDX_W-1:0]     w_lin;
    logic                 w_over;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_fresh_inc;
    logic                 w_new;
    t_status              w_status;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    assign w_per       = (r_epb == '0) ? FLD_W'(1) : r_epb;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_count_m1  = r_count - 1'b1;
    assign w_lin       = r_prod + IDX_W'(r_off);
    assign w_over      = |w_div_rsp.quot[IDX_W-1:FLD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epb <= EPB_RESET;
        end else if (i_cfg.valid) begin
            r_epb <= i_cfg.data;
        end
    end

    bsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer: next state, divider launch and commit.
    always_comb begin
        n_state            = r_state;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_rd_data;
        w_div_req.divisor  = w_per;
        w_commit           = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (t_cmd'(i_in.cmd) == CMD_FREE) begin
                        n_state = S_DONE;
                    end else if (r_count != '0) begin
                        // wait in S_LOAD for the registered top-of-stack read
                        n_state = S_LOAD;
                    end else begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = r_fresh;
                        n_state            = S_DIV;
                    end
                end
            end
            S_LOAD: begin
                w_div_req.start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result and state updates for the command in its final step.
    always_comb begin
        w_status    = ST_OK;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_fresh_inc = 1'b0;
        w_new       = 1'b0;
        if (r_cmd == CMD_FREE) begin
            if (r_full) begin
                w_status = ST_FULL;
            end else begin
                w_push = w_commit;
            end
        end else if (w_over) begin
            // block number past the limit: report, change nothing
            w_status = ST_EXHAUSTED;
        end else begin
            w_new       = ({1'b0, w_div_rsp.quot[FLD_W-1:0]} >= r_blocks);
            w_pop       = w_commit && r_from_stack;
            w_fresh_inc = w_commit && !r_from_stack;
        end
    end

    // Capture the command at acceptance; form the product for a free right away.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= t_cmd'(i_in.cmd);
            r_full       <= (r_count >= CNT_W'(FREE_DEPTH));
            r_from_stack <= (r_count != '0);
            r_off        <= i_in.free_offset;
            r_prod       <= IDX_W'(i_in.free_block) * IDX_W'(w_per);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_fresh  <= '0;
            r_blocks <= '0;
        end else begin
            if (w_push) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop) begin
                r_count <= w_count_m1;
            end
            if (w_fresh_inc) begin
                r_fresh <= r_fresh + 1'b1;
            end
            if (w_commit && w_new && r_cmd == CMD_ALLOC && !w_over) begin
                r_blocks <= {1'b0, w_div_rsp.quot[FLD_W-1:0]} + 1'b1;
            end
        end
    end

    // Free stack memory: one write port, one registered read of the top entry.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[r_count[ADDR_W-1:0]] <= w_lin;
        end
        r_rd_data <= r_stack[w_count_m1[ADDR_W-1:0]];
    end

    // Output register: load on commit, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status <= w_status;
            r_new    <= w_new;
            if (r_cmd == CMD_ALLOC && !w_over) begin
                r_blk  <= w_div_rsp.quot[FLD_W-1:0];
                r_boff <= w_div_rsp.rem;
            end else begin
                r_blk  <= '0;
                r_boff <= '0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.slot_block  = r_blk;
    assign o_out.slot_offset = r_boff;
    assign o_out.new_block   = r_new;

endmodule

[verif/bsa_slot_checker.sv]
// Scoreboard for the block slot allocator: predicts every command's result and checks o_out.
module bsa_slot_checker import bsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bsa_cfg_if   i_cfg,
    bsa_in_if    i_in,
    bsa_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [IDX_W-1:0] BLOCK_LIMIT = IDX_W'(16'hFFFF);

    typedef struct packed {
        t_status          status;
        logic [FLD_W-1:0] slot_block;
        logic [FLD_W-1:0] slot_offset;
        logic             new_block;
    } t_slot_result;

    logic [IDX_W-1:0]     freed_slots [FREE_DEPTH];
    int                   free_top;
    logic [IDX_W-1:0]     next_fresh;
    logic [BLK_CNT_W-1:0] blocks_touched;
    logic [FLD_W-1:0]     slots_per_block;
    t_slot_result         expected_slots [$];

    // Work out the result of one command and advance the allocator state.
    task automatic predict_slot_result(input t_cmd c, input logic [FLD_W-1:0] blk,
                                       input logic [FLD_W-1:0] off, output t_slot_result r);
        logic [FLD_W-1:0] per;
        logic [IDX_W-1:0] lin;
        logic [IDX_W-1:0] quot;
        logic [IDX_W-1:0] remd;
        logic             popped;
        r = '0;
        r.status = ST_OK;
        per = (slots_per_block == '0) ? FLD_W'(1) : slots_per_block;
        if (c == CMD_FREE) begin
            if (free_top >= FREE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                freed_slots[free_top] = IDX_W'(blk) * IDX_W'(per) + IDX_W'(off);
                free_top++;
            end
        end else begin
            popped = (free_top != 0);
            lin    = popped ? freed_slots[free_top-1] : next_fresh;
            quot   = lin / IDX_W'(per);
            remd   = lin % IDX_W'(per);
            if (quot > BLOCK_LIMIT) begin
                // nothing popped, counter held
                r.status = ST_EXHAUSTED;
            end else begin
                if (popped) free_top--;
                else        next_fresh++;
                if (BLK_CNT_W'(quot) >= blocks_touched) begin
                    blocks_touched = BLK_CNT_W'(quot) + BLK_CNT_W'(1);
                    r.new_block    = 1'b1;
                end
                r.slot_block  = quot[FLD_W-1:0];
                r.slot_offset = remd[FLD_W-1:0];
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_result want;
        t_slot_result got;
        if (!i_rst_n) begin
            free_top        = 0;
            next_fresh      = '0;
            blocks_touched  = '0;
            slots_per_block = EPB_RESET;
            expected_slots.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) slots_per_block = i_cfg.data;
            // Check the outgoing result before queuing this edge's command.
            if (i_res.valid && i_res.ready) begin
                got.status      = t_status'(i_res.status);
                got.slot_block  = i_res.slot_block;
                got.slot_offset = i_res.slot_offset;
                got.new_block   = i_res.new_block;
                if (expected_slots.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: status=%0d blk=%0d off=%0d new=%0d",
                                 got.status, got.slot_block, got.slot_offset, got.new_block);
                end else begin
                    want = expected_slots.pop_front();
                    if (got.status !== want.status || got.slot_block !== want.slot_block ||
                        got.slot_offset !== want.slot_offset ||
                        got.new_block !== want.new_block) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected status=%0d blk=%0d off=%0d new=%0d,",
                                     want.status, want.slot_block, want.slot_offset,
                                     want.new_block,
                                     " got status=%0d blk=%0d off=%0d new=%0d",
                                     got.status, got.slot_block, got.slot_offset,
                                     got.new_block);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_slot_result(t_cmd'(i_in.cmd), i_in.free_block, i_in.free_offset, want);
                expected_slots.push_back(want);
            end
        end
        o_pending = expected_slots.size();
    end

endmodule

[verif/tb_block_slot_allocator.sv]
// Testbench top for the block slot allocator: clock, reset, command traffic and verdict.
module tb_block_slot_allocator;
    import bsa_pkg::*;

    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int STALL_LIMIT  = 5000;
    // Settle time after the last result.
    localparam int DRAIN_CYCLES = 40;

    logic             clk;
    logic             rst_n;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               fail_count;
    int               pending;
    int               stall_cycles;
    int               allocs_sent;
    logic [FLD_W-1:0] cur_epb;

    bsa_cfg_if cfg_ch ();
    bsa_in_if  cmd_ch ();
    bsa_out_if res_ch ();

    block_slot_allocator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    bsa_slot_checker u_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // Receiver: drop ready at random on each falling edge; never stall when the rate is zero.
    always @(negedge clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge clk) begin
        if ((cfg_ch.valid && cfg_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one command after a random gap and hold it until the transaction completes.
    // Valid stays high afterwards; the next call or a drain decides its next value.
    task automatic issue_command(input t_cmd c, input logic [FLD_W-1:0] blk,
                                 input logic [FLD_W-1:0] off);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= c;
        cmd_ch.free_block  <= blk;
        cmd_ch.free_offset <= off;
        if (c == CMD_ALLOC) allocs_sent++;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
    endtask

    // Drop valid, then hold until every accepted command has its result back.
    // Each command yields exactly one result, so an empty scoreboard means an idle block.
    task automatic wait_quiescent();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_slots_per_block(input logic [FLD_W-1:0] value);
        wait_quiescent();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_epb = value;
    endtask

    // Mostly plausible traffic: frees name blocks near those handed out so far, with
    // offsets inside the block. A wild share frees arbitrary block/offset pairs.
    task automatic random_traffic(input int count, input int wild_pct);
        int               k;
        int               per;
        int               top_blk;
        t_cmd             c;
        logic [FLD_W-1:0] blk;
        logic [FLD_W-1:0] off;
        for (k = 0; k < count; k++) begin
            per     = (cur_epb == '0) ? 1 : int'(cur_epb);
            top_blk = allocs_sent / per + 1;
            if (top_blk > 65535) top_blk = 65535;
            c = ($urandom_range(0, 99) < 45) ? CMD_FREE : CMD_ALLOC;
            if ($urandom_range(0, 99) < wild_pct) begin
                blk = FLD_W'($urandom);
                off = FLD_W'($urandom);
            end else begin
                blk = FLD_W'($urandom_range(0, top_blk));
                off = FLD_W'($urandom_range(0, per - 1));
            end
            issue_command(c, blk, off);
        end
    endtask

    // Frees only: overrun the free stack to hit the full case.
    task automatic fill_free_stack(input int count);
        int k;
        for (k = 0; k < count; k++)
            issue_command(CMD_FREE, FLD_W'($urandom_range(0, allocs_sent + 1)), '0);
    endtask

    initial begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        stall_cycles       = 0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.cmd         = CMD_ALLOC;
        cmd_ch.free_block  = '0;
        cmd_ch.free_offset = '0;
        res_ch.ready       = 1'b0;
        cur_epb            = EPB_RESET;
        allocs_sent        = 0;
        send_idle_pct      = 34;
        recv_idle_pct      = 82;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset value of one slot per block: fresh allocations, reuse,
        // an index whose block passes the limit (stays stuck on top), a skipped block.
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_FREE, 16'd0, 16'd0);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_FREE, 16'hFFFF, 16'hFFFF);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_FREE, 16'd2, 16'd1);
        issue_command(CMD_ALLOC, '0, '0);
        // Zero acts as one: the stuck index is still out of range.
        write_slots_per_block('0);
        issue_command(CMD_ALLOC, '0, '0);
        // Widest blocks: the stored index is reinterpreted and finally pops.
        write_slots_per_block(16'hFFFF);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_ALLOC, '0, '0);
        // Offset not below the block size is pushed as computed.
        issue_command(CMD_FREE, 16'd1, 16'hFFFF);
        issue_command(CMD_ALLOC, '0, '0);
        write_slots_per_block(16'd3);
        issue_command(CMD_FREE, 16'd7, 16'd5);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_FREE, 16'd0, 16'd7);
        issue_command(CMD_ALLOC, '0, '0);

        // Sender mostly busy, receiver mostly stalled.
        write_slots_per_block(16'd2);
        random_traffic(250, 0);
        write_slots_per_block(16'hFFFF);
        random_traffic(200, 0);

        // Swap the idle rates; overrun the free stack once.
        send_idle_pct = 82;
        recv_idle_pct = 34;
        write_slots_per_block(16'd1);
        fill_free_stack(260);
        random_traffic(250, 0);
        write_slots_per_block('0);
        random_traffic(200, 0);

        // Full rate on both sides; add wild frees last so they do not saturate
        // the block count early.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_slots_per_block(FLD_W'($urandom_range(2, 40)));
        random_traffic(300, 0);
        write_slots_per_block(FLD_W'($urandom_range(1, 65535)));
        random_traffic(250, 5);
        write_slots_per_block(16'd5);
        random_traffic(250, 5);

        // Directed tail: last legal block, field bit patterns, then past the limit.
        write_slots_per_block(16'd1);
        issue_command(CMD_FREE, 16'hFFFF, 16'h0000);
        issue_command(CMD_ALLOC, '0, '0);
        issue_command(CMD_FREE, 16'hAAAA, 16'h5555);
        issue_command(CMD_ALLOC, 16'h5555, 16'hAAAA);
        issue_command(CMD_FREE, 16'h5555, 16'hAAAA);
        issue_command(CMD_ALLOC, 16'hAAAA, 16'h5555);
        issue_command(CMD_FREE, 16'hFFFF, 16'hFFFF);
        issue_command(CMD_ALLOC, 16'hFFFF, 16'hFFFF);

        wait_quiescent();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[block_slot_allocator.f]
rtl/bsa_pkg.sv
rtl/bsa_ifs.sv
rtl/bsa_div.sv
rtl/block_slot_allocator.sv
verif/bsa_slot_checker.sv
verif/tb_block_slot_allocator.sv
